FILE: rtl/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

   localparam int unsigned MAX_RECORDS = 3;

   localparam logic [5:0] HEADER_LEN   = 6'd8;
   localparam logic [5:0] CSUM_BYTES   = 6'd2;
   localparam logic [5:0] POS_MAX      = 6'd63;

   localparam int unsigned RECORD_KINDS     = 3;
   localparam int unsigned WORDS_PER_RECORD = 4;

   typedef logic [15:0] word_type;
   typedef logic [1:0]  rec_idx_type;

   localparam rec_idx_type REC_OPPONENT     = 2'd0;
   localparam rec_idx_type REC_SECOND_OPP   = 2'd1;
   localparam rec_idx_type REC_SECOND_ROBOT = 2'd2;

   localparam logic CSR_SECOND_OPP_EN   = 1'b0;
   localparam logic CSR_SECOND_ROBOT_EN = 1'b1;

   // header "tnenoppo"
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h74;
         3'd1: c = 8'h6e;
         3'd2: c = 8'h65;
         3'd3: c = 8'h6e;
         3'd4: c = 8'h6f;
         3'd5: c = 8'h70;
         3'd6: c = 8'h70;
         3'd7: c = 8'h6f;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/position_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// req_      in   tvalid/tready    tdata[7:0] rx_byte
// rsp_      out  tvalid/tready    tdata[63:0] x,y,angle,distance; tuser[2:0]; tlast
// csr_      in   we               index[0], wdata[0]
//
// One byte is taken per cycle. The closing byte of a frame loads the result
// buffer; the checksum sum is formed in the following cycle and the records
// leave one per cycle, while rsp_tready is high, from the cycle after that.
// req_tready drops only when the next byte would close a frame while the
// buffer still holds undelivered results. Reset is synchronous.
module position_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] angle, [63:48] distance
   output logic [2:0]  rsp_tuser,   // [1:0] record_index, [2] checksum_ok
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   localparam int unsigned NR = pfd_pkg::RECORD_KINDS;
   localparam int unsigned NW = pfd_pkg::WORDS_PER_RECORD;

   logic            so_en_ff, sr_en_ff;
   logic [5:0]      bp_ff, bp_in;
   logic            pay_ff, pay_in;
   pfd_pkg::word_type rec_ff [NR][NW];
   pfd_pkg::word_type rec_in [NR][NW];
   pfd_pkg::word_type csum_ff, csum_in;

   pfd_pkg::word_type snap_ff [NR][NW];
   pfd_pkg::word_type snap_csum_ff;
   logic [2:0]      snap_incl_ff;
   logic [1:0]      snap_n_ff;
   logic            chk_pend_ff;
   logic            out_valid_ff;
   logic            ok_ff;
   logic [1:0]      out_k_ff;

   logic            incl1, incl2;
   logic [1:0]      n1, n_rec;
   logic [5:0]      frame_len, bp_inc, off, rec_bytes;
   logic [2:0]      off_blk;
   logic [1:0]      rid;
   logic            req_acc, rsp_acc, frame_end, end_next, busy;
   pfd_pkg::word_type rsum [NR];
   pfd_pkg::word_type total;
   pfd_pkg::rec_idx_type sel;

   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;

   assign incl1     = so_en_ff && (pfd_pkg::MAX_RECORDS > 1);
   assign n1        = 2'd1 + {1'b0, incl1};
   assign incl2     = sr_en_ff && (32'(n1) < pfd_pkg::MAX_RECORDS);
   assign n_rec     = n1 + {1'b0, incl2};
   assign rec_bytes = {1'b0, n_rec, 3'b000};
   assign frame_len = pfd_pkg::HEADER_LEN + rec_bytes + pfd_pkg::CSUM_BYTES;
   assign bp_inc    = (bp_ff == pfd_pkg::POS_MAX) ? bp_ff : bp_ff + 6'd1;
   assign off       = (bp_ff >= pfd_pkg::HEADER_LEN) ? bp_ff - pfd_pkg::HEADER_LEN : 6'd0;
   assign off_blk   = off[5:3];

   always_comb begin
      priority if (off_blk == 3'd0) begin
         rid = pfd_pkg::REC_OPPONENT;
      end else if (off_blk == 3'd1 && incl1) begin
         rid = pfd_pkg::REC_SECOND_OPP;
      end else begin
         rid = pfd_pkg::REC_SECOND_ROBOT;
      end
   end

   assign busy       = chk_pend_ff | out_valid_ff;
   assign end_next   = pay_ff && (bp_inc >= frame_len);
   assign req_tready = !(busy && end_next);

   always_comb begin
      bp_in     = bp_ff;
      pay_in    = pay_ff;
      rec_in    = rec_ff;
      csum_in   = csum_ff;
      frame_end = 1'b0;
      if (req_acc) begin
         if (!pay_ff) begin
            if (bp_ff < pfd_pkg::HEADER_LEN && req_tdata == pfd_pkg::hdr_char(bp_ff[2:0])) begin
               bp_in = bp_ff + 6'd1;
            end else begin
               bp_in = 6'd0;
            end
            if (bp_in >= pfd_pkg::HEADER_LEN) begin
               bp_in  = pfd_pkg::HEADER_LEN;
               pay_in = 1'b1;
            end
         end else begin
            if (off_blk < {1'b0, n_rec}) begin
               if (off[0]) begin
                  rec_in[rid][off[2:1]] = {rec_ff[rid][off[2:1]][15:8] | req_tdata,
                                           rec_ff[rid][off[2:1]][7:0]};
               end else begin
                  rec_in[rid][off[2:1]] = {8'h00, req_tdata};
               end
            end else if (off == rec_bytes) begin
               csum_in = {8'h00, req_tdata};
            end else if (off == rec_bytes + 6'd1) begin
               csum_in = {csum_ff[15:8] | req_tdata, csum_ff[7:0]};
            end
            bp_in = bp_inc;
            if (bp_inc >= frame_len) begin
               frame_end = 1'b1;
               bp_in     = 6'd0;
               pay_in    = 1'b0;
            end
         end
      end
   end

   // checksum over the buffered frame
   always_comb begin
      for (int r = 0; r < NR; r++) begin
         rsum[r] = snap_incl_ff[r] ?
                   snap_ff[r][0] + snap_ff[r][1] + snap_ff[r][2] + snap_ff[r][3] : 16'h0000;
      end
      total = rsum[0] + rsum[1] + rsum[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         so_en_ff     <= 1'b0;
         sr_en_ff     <= 1'b0;
         bp_ff        <= 6'd0;
         pay_ff       <= 1'b0;
         csum_ff      <= '0;
         chk_pend_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_k_ff     <= 2'd0;
         for (int r = 0; r < NR; r++) begin
            for (int w = 0; w < NW; w++) begin
               rec_ff[r][w] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pfd_pkg::CSR_SECOND_OPP_EN:   so_en_ff <= csr_wdata[0];
               pfd_pkg::CSR_SECOND_ROBOT_EN: sr_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         bp_ff   <= bp_in;
         pay_ff  <= pay_in;
         rec_ff  <= rec_in;
         csum_ff <= csum_in;
         chk_pend_ff <= frame_end;
         if (chk_pend_ff) begin
            out_valid_ff <= 1'b1;
            out_k_ff     <= 2'd0;
         end else if (rsp_acc) begin
            if (rsp_tlast) begin
               out_valid_ff <= 1'b0;
            end else begin
               out_k_ff <= out_k_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         snap_ff      <= rec_in;
         snap_csum_ff <= csum_in;
         snap_incl_ff <= {incl2, incl1, 1'b1};
         snap_n_ff    <= n_rec;
      end
      if (chk_pend_ff) begin
         ok_ff <= (total == snap_csum_ff);
      end
   end

   // with no second opponent the second slot carries the second robot
   always_comb begin
      priority if (out_k_ff == 2'd0) begin
         sel = pfd_pkg::REC_OPPONENT;
      end else if (out_k_ff == 2'd1 && snap_incl_ff[1]) begin
         sel = pfd_pkg::REC_SECOND_OPP;
      end else begin
         sel = pfd_pkg::REC_SECOND_ROBOT;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {snap_ff[sel][3], snap_ff[sel][2], snap_ff[sel][1], snap_ff[sel][0]};
   assign rsp_tuser  = {ok_ff, sel};
   assign rsp_tlast  = (out_k_ff == snap_n_ff - 2'd1);

endmodule

FILE: rtl/pfd_checker.sv
`timescale 1ns / 1ps

module pfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_idx_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("illegal record index");

   a_robot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == pfd_pkg::REC_SECOND_ROBOT |-> rsp_tlast)
      else $error("second robot record not last of frame");

   // records of one frame follow without gaps
   a_frame_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside frame results");

endmodule

bind position_frame_deframer_unit pfd_checker u_pfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [63:0] SYNC_WORD      = "tnenoppo";
   localparam int          SYNC_LEN       = 8;
   localparam int          POS_LIMIT      = 63;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 8;

   typedef enum int {PAT_RANDOM, PAT_EXTREMES, PAT_ONES} word_pattern_type;

   typedef struct {
      pfd_pkg::rec_idx_type kind;
      pfd_pkg::word_type    x;
      pfd_pkg::word_type    y;
      pfd_pkg::word_type    ang;
      pfd_pkg::word_type    distance;
      logic                 ok;
      logic                 last;
   } position_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [15:0] pos_x, [31:16] pos_y, [47:32] angle, [63:48] distance
   logic [2:0]  rsp_tuser;           // [1:0] record_index, [2] checksum_ok
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = 1'b0;
   logic [0:0]  csr_wdata = 1'b0;

   int gap_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int sent_bytes = 0;
   int idle_cycles = 0;

   // deframer shadow state
   logic                opp_en = 1'b0;
   logic                robot_en = 1'b0;
   logic                in_frame = 1'b0;
   int                  frame_pos = 0;
   pfd_pkg::word_type   words [12];
   pfd_pkg::word_type   rx_sum = '0;
   position_record_type pending [$];
   position_record_type want;

   position_frame_deframer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] sync_char(input int i);
      return SYNC_WORD[63 - 8 * i -: 8];
   endfunction

   function automatic int records_in_frame();
      int n;
      n = 1;
      if (opp_en && n < pfd_pkg::MAX_RECORDS && n < pfd_pkg::RECORD_KINDS) n++;
      if (robot_en && n < pfd_pkg::MAX_RECORDS && n < pfd_pkg::RECORD_KINDS) n++;
      return n;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      pfd_pkg::rec_idx_type order [3];
      int                   n, off, frame_end, slot, k, w;
      pfd_pkg::word_type    total;
      position_record_type  r;
      if (!in_frame) begin
         // a mismatching byte is not retried as the first header byte
         if (frame_pos < SYNC_LEN && b == sync_char(frame_pos)) frame_pos++;
         else frame_pos = 0;
         if (frame_pos >= SYNC_LEN) begin
            frame_pos = SYNC_LEN;
            in_frame = 1'b1;
         end
      end else begin
         n = 1;
         order[0] = pfd_pkg::REC_OPPONENT;
         if (opp_en && n < pfd_pkg::MAX_RECORDS && n < pfd_pkg::RECORD_KINDS) begin
            order[n] = pfd_pkg::REC_SECOND_OPP;
            n++;
         end
         if (robot_en && n < pfd_pkg::MAX_RECORDS && n < pfd_pkg::RECORD_KINDS) begin
            order[n] = pfd_pkg::REC_SECOND_ROBOT;
            n++;
         end
         frame_end = SYNC_LEN + 8 * n + 2;
         off = (frame_pos >= SYNC_LEN) ? frame_pos - SYNC_LEN : 0;
         if (off / 8 < n) begin
            slot = int'(order[off / 8]) * pfd_pkg::WORDS_PER_RECORD + (off / 2) % 4;
            if (off % 2) words[slot] = words[slot] | {b, 8'h00};
            else words[slot] = {8'h00, b};
         end else if (off == 8 * n) begin
            rx_sum = {8'h00, b};
         end else if (off == 8 * n + 1) begin
            rx_sum = rx_sum | {b, 8'h00};
         end
         if (frame_pos < POS_LIMIT) frame_pos++;
         if (frame_pos >= frame_end) begin
            total = '0;
            for (k = 0; k < n; k++)
               for (w = 0; w < pfd_pkg::WORDS_PER_RECORD; w++)
                  total += words[int'(order[k]) * pfd_pkg::WORDS_PER_RECORD + w];
            for (k = 0; k < n; k++) begin
               slot       = int'(order[k]) * pfd_pkg::WORDS_PER_RECORD;
               r.kind     = order[k];
               r.x        = words[slot];
               r.y        = words[slot + 1];
               r.ang      = words[slot + 2];
               r.distance = words[slot + 3];
               r.ok       = (total == rx_sum);
               r.last     = (k == n - 1);
               pending.push_back(r);
            end
            frame_pos = 0;
            in_frame = 1'b0;
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b);
      sent_bytes++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_layout(input bit opp, input bit robot);
      settle();
      csr_we    <= 1'b1;
      csr_index <= pfd_pkg::CSR_SECOND_OPP_EN;
      csr_wdata <= opp;
      @(posedge clock);
      opp_en = opp;
      csr_index <= pfd_pkg::CSR_SECOND_ROBOT_EN;
      csr_wdata <= robot;
      @(posedge clock);
      robot_en = robot;
      csr_we <= 1'b0;
   endtask

   task automatic send_frame(input word_pattern_type pattern, input bit good_sum);
      int                n, i;
      pfd_pkg::word_type w, total;
      n = records_in_frame();
      for (i = 0; i < SYNC_LEN; i++) send_byte(sync_char(i));
      total = '0;
      for (i = 0; i < 4 * n; i++) begin
         case (pattern)
            PAT_EXTREMES: begin
               case (i % 4)
                  0: w = 16'h0000;
                  1: w = 16'hffff;
                  2: w = 16'h8000;
                  default: w = 16'h7fff;
               endcase
            end
            PAT_ONES: w = 16'hffff;
            default: begin
               case ($urandom_range(0, 9))
                  0: w = 16'h8000;
                  1: w = 16'h7fff;
                  2: w = 16'h0000;
                  3: w = 16'hffff;
                  default: w = 16'($urandom);
               endcase
            end
         endcase
         total += w;
         send_byte(w[7:0]);
         send_byte(w[15:8]);
      end
      if (!good_sum) total ^= 16'($urandom_range(1, 65535));
      send_byte(total[7:0]);
      send_byte(total[15:8]);
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] exp_val);
      $display("error at %0t: %s got %h, expected %h", $realtime, field, got, exp_val);
      errors++;
   endtask

   task automatic test_layouts();
      int cfg;
      gap_pct   = 0;
      stall_pct = 0;
      for (cfg = 0; cfg < 4; cfg++) begin
         set_layout(cfg[0], cfg[1]);
         send_frame(PAT_EXTREMES, 1'b1);
         send_frame(PAT_ONES, 1'b0);
      end
   endtask

   task automatic test_header_slip();
      int i;
      set_layout(1'b0, 1'b0);
      // doubled first character: header is lost
      send_byte(sync_char(0));
      send_frame(PAT_EXTREMES, 1'b1);
      send_frame(PAT_RANDOM, 1'b1);
      // header cut short and restarted
      for (i = 0; i < 4; i++) send_byte(sync_char(i));
      send_frame(PAT_RANDOM, 1'b1);
      send_frame(PAT_RANDOM, 1'b1);
   endtask

   task automatic test_layout_change_in_frame();
      int i;
      // shrink: remaining bytes fall outside every slot
      set_layout(1'b1, 1'b1);
      for (i = 0; i < SYNC_LEN; i++) send_byte(sync_char(i));
      repeat (22) send_byte(8'($urandom));
      set_layout(1'b0, 1'b0);
      while (in_frame) send_byte(8'($urandom));
      // grow
      for (i = 0; i < SYNC_LEN; i++) send_byte(sync_char(i));
      repeat (4) send_byte(8'($urandom));
      set_layout(1'b1, 1'b1);
      while (in_frame) send_byte(8'($urandom));
   endtask

   task automatic test_random_phase(input int gap, input int stall, input int budget);
      int target, choice, cut, i;
      set_layout(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gap_pct   = gap;
      stall_pct = stall;
      target    = sent_bytes + budget;
      while (sent_bytes < target) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_frame(PAT_RANDOM, $urandom_range(0, 3) != 0);
         end else if (choice == 7) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else begin
            cut = $urandom_range(1, 7);
            for (i = 0; i < cut; i++) send_byte(sync_char(i));
            send_byte(8'($urandom));
         end
      end
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            report_mismatch("record with none outstanding, pos_x", rsp_tdata[15:0], 16'h0);
         end else begin
            want = pending.pop_front();
            if (rsp_tuser[1:0] !== want.kind)
               report_mismatch("record_index", 16'(rsp_tuser[1:0]), 16'(want.kind));
            if (rsp_tdata[15:0] !== want.x) report_mismatch("pos_x", rsp_tdata[15:0], want.x);
            if (rsp_tdata[31:16] !== want.y) report_mismatch("pos_y", rsp_tdata[31:16], want.y);
            if (rsp_tdata[47:32] !== want.ang)
               report_mismatch("angle", rsp_tdata[47:32], want.ang);
            if (rsp_tdata[63:48] !== want.distance)
               report_mismatch("distance", rsp_tdata[63:48], want.distance);
            if (rsp_tuser[2] !== want.ok)
               report_mismatch("checksum_ok", 16'(rsp_tuser[2]), 16'(want.ok));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 16'(rsp_tlast), 16'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int phase;
      foreach (words[i]) words[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_layouts();
      test_header_slip();
      test_layout_change_in_frame();
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: test_random_phase(0, 0, 30);
            1: test_random_phase(71, 0, 30);
            2: test_random_phase(0, 71, 30);
            default: test_random_phase(22, 22, 30);
         endcase
      end
      settle();
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: position_frame_deframer_unit.f
rtl/pfd_pkg.sv
rtl/position_frame_deframer_unit.sv
rtl/pfd_checker.sv
test/testbench.sv
